[rtl/core/dtrg_pkg.sv]
// Shared types, constants and controller codes for the diphthong track ramp generator.
`timescale 1ns / 1ps

package dtrg_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int FRAC_BITS      = 5;
    localparam int FRAC_HALF      = 16;
    localparam int ACC_W          = 24;
    localparam int DIV_BITS       = 3;
    localparam int DIV_CYCLES     = ACC_W / DIV_BITS;

    typedef struct packed {
        logic signed [15:0] hold_value;
        logic signed [15:0] end_value;
        logic signed [15:0] boundary_value;
        logic [6:0]         seg_length;
        logic [6:0]         center_point;
        logic [9:0]         ramp_length;
    } dtrg_in_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } dtrg_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BDIV,
        ST_BMUL,
        ST_BPREV,
        ST_FSTART,
        ST_FDIV,
        ST_EMIT
    } dtrg_state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic div_start;
        logic div_fwd;
        logic db_load;
        logic df_load;
        logic mul;
        logic prev_load;
        logic emit;
    } dtrg_cmd_t;

    typedef struct packed {
        logic empty;
        logic tb_pos;
        logic tf_pos;
        logic div_done;
        logic slot_free;
        logic idx_last;
    } dtrg_status_t;

endpackage

[rtl/core/dtrg_div.sv]
// Signed-by-unsigned truncating divider, three quotient bits per cycle.
`timescale 1ns / 1ps

module dtrg_div
    import dtrg_pkg::*;
#(
    parameter int CW = 7
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic [CW-1:0]           divisor,
    output logic                    busy,
    output logic                    done,
    output logic signed [ACC_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_CYCLES);

    logic [ACC_W-1:0] work_reg;
    logic [ACC_W-1:0] work_next;
    logic [CW-1:0]    rem_reg;
    logic [CW-1:0]    rem_next;
    logic [CW-1:0]    dvs_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CW:0]      trial;

    always_comb begin
        work_next = work_reg;
        rem_next  = rem_reg;
        trial     = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial     = {rem_next, work_next[ACC_W-1]};
            work_next = {work_next[ACC_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next     = CW'(trial - {1'b0, dvs_reg});
                work_next[0] = 1'b1;
            end else begin
                rem_next = trial[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend[ACC_W-1] ? -dividend : dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            neg_reg  <= dividend[ACC_W-1];
            cnt_reg  <= CNT_W'(DIV_CYCLES - 1);
        end else if (busy_reg) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -work_reg : work_reg;

endmodule

[rtl/core/dtrg_datapath.sv]
// Datapath: segment registers, ramp geometry, divider, accumulator and output register.
`timescale 1ns / 1ps

module dtrg_datapath
    import dtrg_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  dtrg_in_t     s_payload,
    input  dtrg_cmd_t    cmd,
    output dtrg_status_t st,
    output logic         m_valid,
    input  logic         m_ready,
    output dtrg_out_t    m_payload
);

    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam int RW = (CW > 10) ? CW : 10;

    function automatic logic signed [ACC_W-1:0] round_fx(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] q;
        mag = x[ACC_W-1] ? -x : x;
        q   = (mag + ACC_W'(FRAC_HALF)) >> FRAC_BITS;
        return x[ACC_W-1] ? -q : q;
    endfunction

    logic signed [15:0]      hold_reg;
    logic signed [15:0]      endv_reg;
    logic signed [15:0]      bound_reg;
    logic [CW-1:0]           seg_reg;
    logic [CW-1:0]           cen_reg;
    logic [9:0]              ramp_reg;
    logic [CW-1:0]           idx_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] db_reg;
    logic signed [ACC_W-1:0] df_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prev_reg;
    logic                    m_valid_reg;
    dtrg_out_t               m_payload_reg;

    logic [LW-1:0]           seg_in;
    logic [LW-1:0]           cen_in;
    logic [CW-1:0]           seg_sat;
    logic [CW-1:0]           cen_clamp;
    logic [RW-1:0]           ramp_ext;
    logic [CW-1:0]           cen_m1;
    logic [CW-1:0]           tf_raw;
    logic [CW-1:0]           tb;
    logic [CW-1:0]           tf;
    logic                    tb_pos;
    logic                    tf_pos;
    logic signed [ACC_W-1:0] hold_fx;
    logic signed [ACC_W-1:0] bound_fx;
    logic signed [ACC_W-1:0] fwd_dividend;
    logic signed [ACC_W-1:0] div_dividend;
    logic [CW-1:0]           div_divisor;
    logic                    div_busy;
    logic                    div_done;
    logic signed [ACC_W-1:0] div_quot;
    logic signed [CW+ACC_W:0] prod_full;
    logic                    in_b;
    logic                    in_f;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] ramp_val;
    logic signed [15:0]      sample_val;
    logic                    slot_free;
    logic                    step;
    logic                    idx_last;

    // length saturation and centre clamp on the incoming transaction
    assign seg_in    = LW'(s_payload.seg_length);
    assign cen_in    = LW'(s_payload.center_point);
    assign seg_sat   = (seg_in > LW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(seg_in);
    assign cen_clamp = (cen_in > LW'(seg_sat)) ? seg_sat : CW'(cen_in);

    // ramp lengths
    assign ramp_ext = RW'(ramp_reg);
    assign cen_m1   = cen_reg - 1'b1;
    assign tf_raw   = seg_reg - cen_reg - 1'b1;
    assign tb_pos   = (cen_reg >= CW'(2)) && (ramp_reg != '0);
    assign tf_pos   = ((CW+1)'(seg_reg) >= (CW+1)'(cen_reg) + (CW+1)'(2)) && (ramp_reg != '0);
    assign tb       = (RW'(cen_m1) > ramp_ext) ? CW'(ramp_reg) : cen_m1;
    assign tf       = (RW'(tf_raw) > ramp_ext) ? CW'(ramp_reg) : tf_raw;

    assign hold_fx      = ACC_W'(hold_reg) <<< FRAC_BITS;
    assign bound_fx     = ACC_W'(bound_reg) <<< FRAC_BITS;
    assign fwd_dividend = (ACC_W'(endv_reg) - prev_reg) <<< FRAC_BITS;
    assign div_dividend = cmd.div_fwd ? fwd_dividend : (bound_fx - hold_fx);
    assign div_divisor  = cmd.div_fwd ? tf : tb;

    dtrg_div #(
        .CW (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign prod_full = $signed({1'b0, tb}) * db_reg;

    // sample generation
    assign in_b = tb_pos && (idx_reg >= cen_reg - tb) && (idx_reg < cen_reg);
    assign in_f = tf_pos && (idx_reg >= cen_reg) && (idx_reg < cen_reg + tf);
    assign acc_base   = (in_f && idx_reg == cen_reg) ? (prev_reg <<< FRAC_BITS) : acc_reg;
    assign acc_sum    = acc_base + (in_f ? df_reg : db_reg);
    assign ramp_val   = round_fx(acc_sum);
    assign sample_val = (in_b || in_f) ? ramp_val[15:0]
                      : ((idx_reg < cen_reg) ? hold_reg : endv_reg);

    assign slot_free = !m_valid_reg || m_ready;
    assign step      = cmd.emit && slot_free;
    assign idx_last  = (idx_reg == seg_reg - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hold_reg  <= s_payload.hold_value;
            endv_reg  <= s_payload.end_value;
            bound_reg <= s_payload.boundary_value;
            seg_reg   <= seg_sat;
            cen_reg   <= cen_clamp;
            ramp_reg  <= s_payload.ramp_length;
        end
        if (cmd.init) begin
            acc_reg <= hold_fx;
            idx_reg <= '0;
        end else if (step) begin
            idx_reg <= idx_reg + 1'b1;
            if (in_b || in_f) begin
                acc_reg <= acc_sum;
            end
        end
        if (cmd.db_load) begin
            db_reg <= div_quot;
        end
        if (cmd.df_load) begin
            df_reg <= div_quot;
        end
        if (cmd.mul) begin
            prod_reg <= prod_full[ACC_W-1:0];
        end
        if (cmd.prev_load) begin
            prev_reg <= tb_pos ? round_fx(hold_fx + prod_reg) : ACC_W'(hold_reg);
        end
        if (step) begin
            m_payload_reg.sample <= sample_val;
            m_payload_reg.last   <= idx_last;
        end
    end

    assign st.empty     = (seg_reg == '0);
    assign st.tb_pos    = tb_pos;
    assign st.tf_pos    = tf_pos;
    assign st.div_done  = div_done;
    assign st.slot_free = slot_free;
    assign st.idx_last  = idx_last;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (idx_reg < seg_reg))
        else $error("sample index beyond segment");

    a_ramps_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && in_f) |-> !in_b)
        else $error("backward and forward ramps overlap");

endmodule

[rtl/core/dtrg_ctrl.sv]
// Controller: sequences load, divisions, start value and sample emission.
`timescale 1ns / 1ps

module dtrg_ctrl
    import dtrg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  dtrg_status_t st,
    output dtrg_cmd_t    cmd
);

    dtrg_state_t state_reg;
    dtrg_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.init = 1'b1;
                if (st.empty) begin
                    state_next = ST_IDLE;
                end else if (st.tb_pos) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_BDIV;
                end else begin
                    cmd.prev_load = 1'b1;
                    state_next    = ST_FSTART;
                end
            end
            ST_BDIV: begin
                if (st.div_done) begin
                    cmd.db_load = 1'b1;
                    state_next  = ST_BMUL;
                end
            end
            ST_BMUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_BPREV;
            end
            ST_BPREV: begin
                cmd.prev_load = 1'b1;
                state_next    = ST_FSTART;
            end
            ST_FSTART: begin
                if (st.tf_pos) begin
                    cmd.div_start = 1'b1;
                    cmd.div_fwd   = 1'b1;
                    state_next    = ST_FDIV;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_FDIV: begin
                if (st.div_done) begin
                    cmd.df_load = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (st.slot_free && st.idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        st.div_done |-> (state_reg == ST_BDIV || state_reg == ST_FDIV))
        else $error("division finished outside a wait state");

    a_fdiv_needs_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FDIV) |-> st.tf_pos)
        else $error("forward division without a forward ramp");

endmodule

[rtl/core/diphthong_track_ramp_generator_unit.sv]
// Top level of the diphthong track ramp generator.
// One input transaction describes a segment and yields min(seg_length, MAX_FRAMES)
// output transactions, one sample each in order of time, the final one with last set;
// an empty segment yields none. After acceptance a segment passes through set-up, the
// shared divider for the backward ramp slope (only when that ramp exists), the forming
// of the ramp end value, the divider for the forward ramp slope (only when that ramp
// exists), then one sample per cycle while m_ready is high. The divider resolves three
// quotient bits a cycle. The next segment is accepted while the final sample still
// waits in the output register.
`timescale 1ns / 1ps

module diphthong_track_ramp_generator_unit
    import dtrg_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dtrg_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output dtrg_out_t m_payload
);

    dtrg_cmd_t    cmd;
    dtrg_status_t st;

    dtrg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    dtrg_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
